/* hdl/prim_minimum_spanning_tree_top_macros.svh */
// assertion macros for the spanning tree block checker
`ifndef PRIM_MINIMUM_SPANNING_TREE_TOP_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_TOP_MACROS_SVH

// same-cycle implication
`define PMST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pmst_pkg.sv */
// shared constants and types of the spanning tree block
package pmst_pkg;

    localparam int MAX_NODES_DEF   = 8;
    localparam int WEIGHT_BITS_DEF = 16;

    // status of one relaxation step
    typedef struct packed {
        logic upd;   // key of the visited node lowered
        logic take;  // visited node is the new best candidate
    } pmst_relax_t;

endpackage

/* hdl/pmst_ram.sv */
// single write port, single registered read port memory
module pmst_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pmst_relax.sv */
// shared relax and minimum compare unit, one node per cycle
module pmst_relax #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic [WEIGHT_BITS-1:0] edge_w,
    input  logic [WEIGHT_BITS-1:0] key,
    input  logic                   key_valid,
    input  logic                   taken,
    input  logic                   best_found,
    input  logic [WEIGHT_BITS-1:0] best_key,
    output logic [WEIGHT_BITS-1:0] new_key,
    output pmst_pkg::pmst_relax_t  flags
);

    logic upd;
    logic new_valid;

    always_comb begin
        upd       = (edge_w != '0) && !taken && (!key_valid || (edge_w < key));
        new_key   = upd ? edge_w : key;
        new_valid = key_valid || upd;
        flags.upd  = upd;
        flags.take = !taken && new_valid && (!best_found || (new_key < best_key));
    end

endmodule

/* hdl/prim_minimum_spanning_tree_top.sv */
// A matrix entry without tlast is stored and gives no result. The tlast entry
// starts the search: one pass per tree node, each pass taking every active node
// through the shared relax unit. Each tree edge then goes through ST_OUT_RD,
// ST_OUT_LD and ST_OUT_WAIT, where it waits on m_tready. No input is taken
// during search or output.
// Reset (aresetn low, synchronous) clears control and sets node_count to MAX_NODES.
module prim_minimum_spanning_tree_top #(
    parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF,
    localparam int NB    = $clog2(MAX_NODES),
    localparam int CB    = $clog2(MAX_NODES + 1),
    localparam int IN_W  = ((2 * NB + WEIGHT_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * NB + WEIGHT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CB-1:0]    cfg_data,   // node_count
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,    // row_node, col_node, edge_weight
    input  logic             s_tlast,    // load_done
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,    // parent_node, child_node, tree_weight
    output logic             m_tuser,    // unreachable
    output logic             m_tlast     // last_edge
);

    localparam int WB = WEIGHT_BITS;
    localparam int KW = NB + WB;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CB-1:0]        count_reg, count_next;
    logic [CB-1:0]        k_reg, k_next;
    logic [NB-1:0]        pick_reg, pick_next;
    logic                 p_valid_reg, p_valid_next;
    logic [NB-1:0]        p_idx_reg, p_idx_next;
    logic                 best_found_reg, best_found_next;
    logic [WB-1:0]        best_key_reg, best_key_next;
    logic [NB-1:0]        best_idx_reg, best_idx_next;
    logic [MAX_NODES-1:0] key_valid_reg, key_valid_next;
    logic [MAX_NODES-1:0] in_tree_reg, in_tree_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic [NB-1:0]        in_row, in_col;
    logic [WB-1:0]        in_w;
    logic                 load_fire, in_range;
    logic [CB-1:0]        n_act;
    logic [WB-1:0]        w_rd;
    logic [KW-1:0]        k_rd;
    logic                 k_we;
    logic [WB-1:0]        new_key;
    pmst_pkg::pmst_relax_t flags;
    logic                 found;
    logic [NB-1:0]        found_idx;
    logic                 reached;

    assign in_row    = s_tdata[NB-1:0];
    assign in_col    = s_tdata[2*NB-1:NB];
    assign in_w      = s_tdata[2*NB+WB-1:2*NB];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign load_fire = s_tvalid && s_tready;
    assign in_range  = (CB'(in_row) < CB'(MAX_NODES)) && (CB'(in_col) < CB'(MAX_NODES));

    always_comb begin
        if (count_reg < CB'(2)) begin
            n_act = CB'(2);
        end else if (count_reg > CB'(MAX_NODES)) begin
            n_act = CB'(MAX_NODES);
        end else begin
            n_act = count_reg;
        end
    end

    pmst_ram #(
        .DEPTH (2 ** (2 * NB)),
        .WIDTH (WB)
    ) u_wmem (
        .aclk  (aclk),
        .we    (load_fire && in_range),
        .waddr ({in_row, in_col}),
        .wdata (in_w),
        .raddr ({pick_reg, k_reg[NB-1:0]}),
        .rdata (w_rd)
    );

    assign k_we = (state_reg == ST_PASS) && p_valid_reg && flags.upd;

    pmst_ram #(
        .DEPTH (2 ** NB),
        .WIDTH (KW)
    ) u_kmem (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (p_idx_reg),
        .wdata ({pick_reg, w_rd}),
        .raddr (k_reg[NB-1:0]),
        .rdata (k_rd)
    );

    pmst_relax #(
        .WEIGHT_BITS (WB)
    ) u_relax (
        .edge_w     (w_rd),
        .key        (k_rd[WB-1:0]),
        .key_valid  (key_valid_reg[p_idx_reg]),
        .taken      (in_tree_reg[p_idx_reg]),
        .best_found (best_found_reg),
        .best_key   (best_key_reg),
        .new_key    (new_key),
        .flags      (flags)
    );

    assign found     = best_found_reg || flags.take;
    assign found_idx = flags.take ? p_idx_reg : best_idx_reg;
    assign reached   = in_tree_reg[k_reg[NB-1:0]];

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pick_next       = pick_reg;
        p_valid_next    = 1'b0;
        p_idx_next      = p_idx_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        best_idx_next   = best_idx_reg;
        key_valid_next  = key_valid_reg;
        in_tree_next    = in_tree_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (load_fire && s_tlast) begin
                    key_valid_next  = '0;
                    in_tree_next    = MAX_NODES'(1);
                    pick_next       = '0;
                    k_next          = '0;
                    best_found_next = 1'b0;
                    state_next      = ST_PASS;
                end
            end
            ST_PASS: begin
                if (k_reg < n_act) begin
                    k_next       = k_reg + CB'(1);
                    p_valid_next = 1'b1;
                    p_idx_next   = k_reg[NB-1:0];
                end
                if (p_valid_reg) begin
                    if (flags.upd) begin
                        key_valid_next[p_idx_reg] = 1'b1;
                    end
                    if (flags.take) begin
                        best_found_next = 1'b1;
                        best_key_next   = new_key;
                        best_idx_next   = p_idx_reg;
                    end
                    if (CB'(p_idx_reg) == n_act - CB'(1)) begin
                        p_valid_next    = 1'b0;
                        best_found_next = 1'b0;
                        if (found) begin
                            in_tree_next[found_idx] = 1'b1;
                            pick_next = found_idx;
                            k_next    = '0;
                        end else begin
                            k_next     = CB'(1);
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                m_tdata_next = '0;
                m_tdata_next[NB-1:0]       = reached ? k_rd[KW-1:WB] : '0;
                m_tdata_next[2*NB-1:NB]    = k_reg[NB-1:0];
                m_tdata_next[2*NB+WB-1:2*NB] = reached ? k_rd[WB-1:0] : '0;
                m_tuser_next  = !reached;
                m_tlast_next  = (k_reg == n_act - CB'(1));
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_tlast_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + CB'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= CB'(MAX_NODES);
            k_reg          <= '0;
            pick_reg       <= '0;
            p_valid_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            key_valid_reg  <= '0;
            in_tree_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tlast_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            pick_reg       <= pick_next;
            p_valid_reg    <= p_valid_next;
            best_found_reg <= best_found_next;
            key_valid_reg  <= key_valid_next;
            in_tree_reg    <= in_tree_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tlast_reg    <= m_tlast_next;
        end
        p_idx_reg    <= p_idx_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* hdl/pmst_check.sv */
// port-level checker for the spanning tree block, bound to the top level
`include "prim_minimum_spanning_tree_top_macros.svh"

module pmst_check #(
    parameter int MAX_NODES   = pmst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF,
    localparam int NB    = $clog2(MAX_NODES),
    localparam int OUT_W = ((2 * NB + WEIGHT_BITS + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    logic [NB-1:0]          parent;
    logic [WEIGHT_BITS-1:0] weight;

    assign parent = m_tdata[NB-1:0];
    assign weight = m_tdata[2*NB+WEIGHT_BITS-1:2*NB];

    `PMST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
    `PMST_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input ready while result pending")
    `PMST_ASSERT_NEXT(a_busy_after_start, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during search")
    `PMST_ASSERT_IMPL(a_unreach_zero, aclk, aresetn, m_tvalid && m_tuser, (parent == '0) && (weight == '0), "unreachable edge not zeroed")
    `PMST_ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready, "block not idle after last edge")

endmodule

bind prim_minimum_spanning_tree_top pmst_check #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
) u_pmst_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/prim_minimum_spanning_tree_top_tb.sv */
// self-checking testbench for the prim spanning tree block: directed table then random runs
module prim_minimum_spanning_tree_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = pmst_pkg::MAX_NODES_DEF;
    localparam int ENTRY_TARGET = 360;

    typedef struct {
        logic [2:0]  parent;
        logic [2:0]  child;
        logic [15:0] weight;
        logic        unreach;
        logic        last;
    } tree_edge_t;

    typedef enum {ROW_CFG, ROW_ENTRY} dir_kind_t;

    typedef struct {
        dir_kind_t   kind;
        logic [3:0]  count;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] weight;
        logic        done;
        bit          typed;
        tree_edge_t  edge_due;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    prim_minimum_spanning_tree_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    logic [15:0] adj_matrix [NODES][NODES];
    logic [3:0]  node_count_q;
    tree_edge_t  tree_edges_due [$];
    dir_row_t    dir_table [$];
    int          mismatch_count;
    int          entries_sent;
    bit          quiet;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int active_count(input logic [3:0] v);
        if (v < 2) return 2;
        if (v > NODES) return NODES;
        return int'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [15:0] random_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'd0;
        if (r < 45) return 16'($urandom_range(1, 4));
        if (r < 55) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // prim search from node 0 over the stored matrix, one edge per node 1..n-1
    function automatic void compute_tree();
        int          n;
        int          pick;
        bit          found;
        logic [16:0] lowest;
        logic [16:0] key [NODES];
        bit          taken [NODES];
        logic [2:0]  par [NODES];
        tree_edge_t  e;
        n = active_count(node_count_q);
        for (int v = 0; v < NODES; v++) begin
            key[v]   = '1;
            taken[v] = 1'b0;
            par[v]   = '0;
        end
        key[0] = '0;
        for (int rnd = 0; rnd < n; rnd++) begin
            lowest = '1;
            pick   = 0;
            found  = 1'b0;
            for (int v = 0; v < n; v++) begin
                if (!taken[v] && key[v] < lowest) begin
                    lowest = key[v];
                    pick   = v;
                    found  = 1'b1;
                end
            end
            if (!found) break;
            taken[pick] = 1'b1;
            for (int k = 0; k < n; k++) begin
                if (adj_matrix[pick][k] != 0 && !taken[k] &&
                    {1'b0, adj_matrix[pick][k]} < key[k]) begin
                    key[k] = {1'b0, adj_matrix[pick][k]};
                    par[k] = 3'(pick);
                end
            end
        end
        for (int v = 1; v < n; v++) begin
            e.parent  = taken[v] ? par[v] : 3'd0;
            e.child   = 3'(v);
            e.weight  = taken[v] ? key[v][15:0] : 16'd0;
            e.unreach = !taken[v];
            e.last    = (v == n - 1);
            tree_edges_due.push_back(e);
        end
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_tree_edge();
        tree_edge_t e;
        if (tree_edges_due.size() == 0) begin
            flag_mismatch("unexpected tree edge child_node", int'(m_tdata[5:3]), 0);
            return;
        end
        e = tree_edges_due.pop_front();
        if (m_tdata[2:0] !== e.parent)
            flag_mismatch("parent_node", int'(m_tdata[2:0]), int'(e.parent));
        if (m_tdata[5:3] !== e.child)
            flag_mismatch("child_node", int'(m_tdata[5:3]), int'(e.child));
        if (m_tdata[21:6] !== e.weight)
            flag_mismatch("tree_weight", int'(m_tdata[21:6]), int'(e.weight));
        if (m_tuser !== e.unreach)
            flag_mismatch("unreachable", int'(m_tuser), int'(e.unreach));
        if (m_tlast !== e.last)
            flag_mismatch("last_edge", int'(m_tlast), int'(e.last));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) check_tree_edge();
    end

    // result side backpressure
    initial begin : sink_proc
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold == 0) hold = pick_gap();
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_entry(input logic [2:0] row, input logic [2:0] col,
                              input logic [15:0] w, input logic done,
                              input bit typed, input tree_edge_t edge_due);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, w, col, row};
        s_tlast  = done;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        entries_sent++;
        adj_matrix[row][col] = w;
        if (done) begin
            if (typed) tree_edges_due.push_back(edge_due);
            else compute_tree();
        end
    endtask

    task automatic send_random_entry(input int n, input logic done);
        tree_edge_t none;
        logic [2:0] row;
        logic [2:0] col;
        none = '{default: '0};
        if ($urandom_range(0, 99) < 85) begin
            row = 3'($urandom_range(0, n - 1));
            col = 3'($urandom_range(0, n - 1));
        end else begin
            row = 3'($urandom_range(0, 7));
            col = 3'($urandom_range(0, 7));
        end
        send_entry(row, col, random_weight(), done, 1'b0, none);
    endtask

    // block must be idle before the count register changes
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (tree_edges_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [3:0] v);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        node_count_q = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic void dir_cfg(input logic [3:0] v);
        dir_row_t d;
        d = '{kind: ROW_CFG, default: '0};
        d.count = v;
        dir_table.push_back(d);
    endfunction

    function automatic void dir_entry(input logic [2:0] row, input logic [2:0] col,
                                      input logic [15:0] w, input logic done);
        dir_row_t d;
        d = '{kind: ROW_ENTRY, default: '0};
        d.row    = row;
        d.col    = col;
        d.weight = w;
        d.done   = done;
        dir_table.push_back(d);
    endfunction

    // single-edge run (two nodes) with the edge typed in
    function automatic void dir_run2(input logic [2:0] row, input logic [2:0] col,
                                     input logic [15:0] w, input logic [15:0] want_w,
                                     input logic unreach);
        dir_row_t d;
        d = '{kind: ROW_ENTRY, default: '0};
        d.row      = row;
        d.col      = col;
        d.weight   = w;
        d.done     = 1'b1;
        d.typed    = 1'b1;
        d.edge_due = '{parent: 3'd0, child: 3'd1, weight: want_w, unreach: unreach, last: 1'b1};
        dir_table.push_back(d);
    endfunction

    initial begin : stim_proc
        int         corner_counts [6];
        int         n;
        int         runs;
        int         burst;
        int         cut;
        int         phase;
        logic [3:0] v;
        tree_edge_t none;

        corner_counts  = '{8, 15, 0, 1, 9, 2};
        none           = '{default: '0};
        mismatch_count = 0;
        entries_sent   = 0;
        quiet          = 1'b0;
        node_count_q   = 4'd8;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        for (int r = 0; r < NODES; r++)
            for (int c = 0; c < NODES; c++) adj_matrix[r][c] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // two nodes: max weight, missing edge, asymmetric entry, self loop, low counts
        dir_cfg(4'd2);
        dir_entry(3'd0, 3'd0, 16'd0, 1'b0);
        dir_entry(3'd1, 3'd1, 16'd0, 1'b0);
        dir_entry(3'd1, 3'd0, 16'hFFFF, 1'b0);
        dir_run2(3'd0, 3'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        dir_run2(3'd0, 3'd1, 16'd0, 16'd0, 1'b1);
        dir_run2(3'd0, 3'd1, 16'd1, 16'd1, 1'b0);
        dir_cfg(4'd0);
        dir_run2(3'd0, 3'd0, 16'd5, 16'd1, 1'b0);
        dir_cfg(4'd1);
        dir_run2(3'd1, 3'd1, 16'd9, 16'd1, 1'b0);
        // three nodes: equal keys go to the lower index, then partial reach
        dir_cfg(4'd3);
        dir_entry(3'd0, 3'd1, 16'd5, 1'b0);
        dir_entry(3'd0, 3'd2, 16'd5, 1'b0);
        dir_entry(3'd1, 3'd0, 16'd0, 1'b0);
        dir_entry(3'd1, 3'd2, 16'd3, 1'b0);
        dir_entry(3'd2, 3'd0, 16'd0, 1'b0);
        dir_entry(3'd2, 3'd1, 16'd0, 1'b0);
        dir_entry(3'd2, 3'd2, 16'd0, 1'b1);
        dir_entry(3'd1, 3'd2, 16'd0, 1'b1);
        dir_entry(3'd0, 3'd2, 16'd0, 1'b1);

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                wait_drained();
                write_node_count(dir_table[i].count);
            end else begin
                send_entry(dir_table[i].row, dir_table[i].col, dir_table[i].weight,
                           dir_table[i].done, dir_table[i].typed, dir_table[i].edge_due);
            end
        end

        // fill the whole matrix so every later read hits a written entry
        for (int r = 0; r < NODES; r++)
            for (int c = 0; c < NODES; c++)
                send_entry(3'(r), 3'(c), random_weight(),
                           (r == NODES - 1 && c == NODES - 1), 1'b0, none);

        phase = 0;
        while (entries_sent < ENTRY_TARGET) begin
            wait_drained();
            quiet = ($urandom_range(0, 4) == 0);
            if (phase < 6) v = 4'(corner_counts[phase]);
            else v = 4'($urandom_range(0, 15));
            write_node_count(v);
            n = active_count(v);
            runs = $urandom_range(1, 3);
            repeat (runs) begin
                if ($urandom_range(0, 5) == 0) begin
                    // cut one node off from every active row
                    cut = $urandom_range(1, n - 1);
                    for (int k = 0; k < n; k++)
                        send_entry(3'(k), 3'(cut), 16'd0, 1'b0, 1'b0, none);
                end
                burst = $urandom_range(0, 10);
                repeat (burst) send_random_entry(n, 1'b0);
                send_random_entry(n, 1'b1);
            end
            phase++;
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/pmst_pkg.sv
hdl/pmst_ram.sv
hdl/pmst_relax.sv
hdl/prim_minimum_spanning_tree_top.sv
hdl/pmst_check.sv
tb/sv/prim_minimum_spanning_tree_top_tb.sv
